@@ rtl/cmapa_pkg.sv @@
// Shared package for the cascaded moving average pulse height block.
// Holds register indexes, fixed field widths and the controller/datapath bundles.
// No dependencies.
package cmapa_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_RECORD_LENGTH = 2'd0;
   localparam logic [1:0] CSR_PRETRIGGER    = 2'd1;
   localparam logic [1:0] CSR_WINDOW_SIZE   = 2'd2;
   localparam logic [1:0] CSR_PASS_COUNT    = 2'd3;

   // Fixed widths from the field and register definitions.
   localparam int CNT_W    = 13;   // record length, positions, divisors
   localparam int WIN_REG_W = 10;
   localparam int PASS_W   = 3;
   localparam int SAMPLE_W = 8;
   localparam int X_W      = 24;   // fixed-point value, 16 fraction bits
   localparam int ENERGY_W = 25;
   localparam int BASE_W   = X_W + CNT_W;

   // Reciprocal of five for an exact floor divide of a 15-bit value.
   localparam logic [16:0] RECIP5 = 17'd52429;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              accept;     // take the input item, open a record if needed
      logic              mem_rd;     // read the delay store for the current pass
      logic              upd;        // update window sum, write delay store, start divide
      logic              x_load;     // take the quotient as the next pass input
      logic              post;       // peak, baseline and position update
      logic              bdiv_start; // start the baseline mean divide
      logic              emit;       // load the result register
      logic [PASS_W-1:0] pass;       // current pass index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              div_done;
      logic              last;       // this sample ends the record
      logic              rsp_full;   // result register cannot take a new item
      logic [PASS_W-1:0] pass_count; // passes latched for the record
   } status_type;

endpackage

@@ rtl/cmapa_div.sv @@
// Iterative signed divider, one quotient bit per cycle, rounding to nearest.
// Ties round away from zero. Depends on cmapa_pkg.
module cmapa_div
   import cmapa_pkg::*;
#(
   parameter int NUM_W = 38
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] numer,
   input  logic [CNT_W-1:0]        denom,
   output logic                    busy,
   output logic                    done,
   output logic signed [X_W-1:0]   quot
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  work_ff, work_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [NUM_W-1:0]  mag;
   logic [CNT_W:0]    rem_sh;

   // Magnitude plus half the divisor gives rounding to nearest.
   always_comb begin
      mag = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
      mag = mag + NUM_W'(denom >> 1);
   end

   // Restoring division step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[CNT_W-1:0], work_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         work_in = mag;
         rem_in  = '0;
         den_in  = denom;
         neg_in  = numer[NUM_W-1];
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in  = rem_sh - {1'b0, den_ff};
            work_in = {work_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            work_in = {work_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -X_W'(work_ff) : X_W'(work_ff);

endmodule

@@ rtl/cmapa_dp.sv @@
// Datapath: configuration registers, delay store memory, window sums,
// peak and baseline tracking and the result register. Depends on cmapa_pkg, cmapa_div.
module cmapa_dp
   import cmapa_pkg::*;
#(
   parameter int MAX_RECORD = 4096,
   parameter int MAX_WINDOW = 512,
   parameter int MAX_PASSES = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [CNT_W-1:0]           csr_data,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  logic                       in_start,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [ENERGY_W-1:0] rsp_energy,
   output logic                       div_busy,
   input  cmd_type                    cmd,
   output status_type                 st
);
   localparam int KW    = $clog2(MAX_WINDOW);
   localparam int PW    = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
   localparam int DEPTH = 2 ** (PW + KW);
   localparam int SUMW  = X_W + 1 + KW;
   localparam int NW    = ((SUMW > BASE_W) ? SUMW : BASE_W) + 1;

   // Configuration registers.
   logic [CNT_W-1:0]     reg_len_ff, reg_pre_ff;
   logic [WIN_REG_W-1:0] reg_win_ff;
   logic [PASS_W-1:0]    reg_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_len_ff  <= CNT_W'(4096);
         reg_pre_ff  <= CNT_W'(512);
         reg_win_ff  <= WIN_REG_W'(500);
         reg_pass_ff <= PASS_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RECORD_LENGTH: reg_len_ff  <= csr_data;
            CSR_PRETRIGGER:    reg_pre_ff  <= csr_data;
            CSR_WINDOW_SIZE:   reg_win_ff  <= csr_data[WIN_REG_W-1:0];
            CSR_PASS_COUNT:    reg_pass_ff <= csr_data[PASS_W-1:0];
            default:           ;
         endcase
      end
   end

   // Effective record settings, clamped into range.
   logic [CNT_W-1:0]  eff_len, eff_win, eff_blen, pre_fifth;
   logic [PASS_W-1:0] eff_pass;
   logic [31:0]       pre_prod;

   always_comb begin
      eff_len = (reg_len_ff == '0) ? CNT_W'(1) : reg_len_ff;
      if (32'(eff_len) > MAX_RECORD) eff_len = CNT_W'(MAX_RECORD);
      eff_win = (reg_win_ff == '0) ? CNT_W'(1) : CNT_W'(reg_win_ff);
      if (32'(eff_win) > MAX_WINDOW) eff_win = CNT_W'(MAX_WINDOW);
      if (eff_win > eff_len) eff_win = eff_len;
      eff_pass = (reg_pass_ff == '0) ? PASS_W'(1) : reg_pass_ff;
      if (32'(eff_pass) > MAX_PASSES) eff_pass = PASS_W'(MAX_PASSES);
      // Four fifths of the pretrigger, floor, via reciprocal multiply.
      pre_prod  = 32'({reg_pre_ff, 2'b00}) * 32'(RECIP5);
      pre_fifth = pre_prod[30:18];
      eff_blen  = (pre_fifth == '0) ? CNT_W'(1) : pre_fifth;
      if (eff_blen > eff_len) eff_blen = eff_len;
   end

   // Record state.
   logic [CNT_W-1:0]        len_ff, win_ff, blen_ff, pos_ff, dvs_ff;
   logic [PASS_W-1:0]       npass_ff;
   logic [KW-1:0]           wptr_ff;
   logic signed [X_W-1:0]   x_ff, peak_ff, old_ff;
   logic signed [BASE_W-1:0] acc_ff;
   logic signed [SUMW-1:0]  sums_ff [MAX_PASSES];
   logic [X_W-1:0]          mem [DEPTH];
   logic [PW+KW-1:0]        addr;
   logic signed [SUMW-1:0]  sum_new;
   logic signed [NW-1:0]    div_num;
   logic [CNT_W-1:0]        div_den;
   logic                    div_start, div_done;
   logic signed [X_W-1:0]   quot;
   logic                    open_rec;

   assign addr     = {cmd.pass[PW-1:0], wptr_ff};
   assign open_rec = in_start || (pos_ff == '0);
   assign sum_new  = sums_ff[cmd.pass[PW-1:0]] + SUMW'(x_ff)
                     - ((pos_ff >= win_ff) ? SUMW'(old_ff) : SUMW'(0));

   // Delay store: registered read, one write per pass update.
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) old_ff <= mem[addr];
      if (cmd.upd) mem[addr] <= x_ff;
   end

   // Sample intake, pass updates and record bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.accept && open_rec) begin
         pos_ff <= '0;
      end else if (cmd.post) begin
         pos_ff <= st.last ? CNT_W'(0) : pos_ff + 1'b1;
      end
      if (cmd.accept) begin
         x_ff <= {in_sample, 16'd0};
         if (open_rec) begin
            len_ff   <= eff_len;
            win_ff   <= eff_win;
            blen_ff  <= eff_blen;
            npass_ff <= eff_pass;
            wptr_ff  <= '0;
            acc_ff   <= '0;
            peak_ff  <= '0;
            for (int i = 0; i < MAX_PASSES; i++) sums_ff[i] <= '0;
         end
      end
      if (cmd.mem_rd) dvs_ff <= (pos_ff < win_ff) ? pos_ff + 1'b1 : win_ff;
      if (cmd.upd) sums_ff[cmd.pass[PW-1:0]] <= sum_new;
      if (cmd.x_load) x_ff <= quot;
      if (cmd.post) begin
         if (pos_ff == '0 || x_ff > peak_ff) peak_ff <= x_ff;
         if (pos_ff < blen_ff) acc_ff <= acc_ff + BASE_W'(x_ff);
         wptr_ff <= (CNT_W'(wptr_ff) + 1'b1 >= win_ff) ? KW'(0) : wptr_ff + 1'b1;
      end
   end

   // Shared divider for pass quotients and the baseline mean.
   assign div_start = cmd.upd || cmd.bdiv_start;
   assign div_num   = cmd.bdiv_start ? NW'(acc_ff) : NW'(sum_new);
   assign div_den   = cmd.bdiv_start ? blen_ff : dvs_ff;

   cmapa_div #(.NUM_W(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   // Result register.
   logic                        rsp_valid_ff;
   logic signed [ENERGY_W-1:0]  energy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) energy_ff <= ENERGY_W'(peak_ff) - ENERGY_W'(quot);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = energy_ff;
   assign st.div_done   = div_done;
   assign st.last       = (pos_ff + 1'b1 >= len_ff);
   assign st.rsp_full   = rsp_valid_ff && !rsp_ready;
   assign st.pass_count = npass_ff;

endmodule

@@ rtl/cmapa_ctrl.sv @@
// Controller state machine: sequences the passes of one sample through the
// delay store and the shared divider. Depends on cmapa_pkg.
module cmapa_ctrl
   import cmapa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type st,
   output cmd_type    cmd
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_UPD    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_POST   = 3'd4;
   localparam logic [2:0] S_BSTART = 3'd5;
   localparam logic [2:0] S_BDIV   = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.accept = 1'b1;
               pass_in    = '0;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.x_load = 1'b1;
               if ({1'b0, pass_ff} + 1'b1 < {1'b0, st.pass_count}) begin
                  pass_in  = pass_ff + 1'b1;
                  state_in = S_READ;
               end else begin
                  state_in = S_POST;
               end
            end
         end
         S_POST: begin
            cmd.post = 1'b1;
            state_in = st.last ? S_BSTART : S_IDLE;
         end
         S_BSTART: begin
            cmd.bdiv_start = 1'b1;
            state_in       = S_BDIV;
         end
         S_BDIV: begin
            if (st.div_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!st.rsp_full) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

@@ rtl/cascaded_moving_average_pulse_height.sv @@
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tdata[7:0] sample, tuser[0] record_start
// rsp     | out | rsp_tvalid/tready   | tdata[24:0] energy
// csr     | in  | csr_valid/csr_ready | csr_index register, csr_data value
//
// Each item runs its passes in turn through the one-bit-per-cycle divider
// shared by all passes, NW = 38 at default parameters; the next item enters
// once it is through. A record's last item adds the baseline mean divide.
// Synchronous active-high reset; no clearing pass. The result register lets
// the next item enter while a result waits; a stalled result holds the block
// only when a second result is ready to be loaded.
module cascaded_moving_average_pulse_height
   import cmapa_pkg::*;
#(
   parameter int MAX_RECORD = 4096,
   parameter int MAX_WINDOW = 512,
   parameter int MAX_PASSES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] sample
   input  logic [0:0]       req_tuser,   // [0] record_start
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // [24:0] energy
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CNT_W-1:0] csr_data
);
   cmd_type                    cmd;
   status_type                 st;
   logic                       div_busy;
   logic signed [ENERGY_W-1:0] energy;

   assign csr_ready = 1'b1;

   cmapa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .st       (st),
      .cmd      (cmd)
   );

   cmapa_dp #(
      .MAX_RECORD (MAX_RECORD),
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_PASSES (MAX_PASSES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_sample  (req_tdata),
      .in_start   (req_tuser[0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_energy (energy),
      .div_busy   (div_busy),
      .cmd        (cmd),
      .st         (st)
   );

   assign rsp_tdata = {7'd0, energy};

   // The divider is never busy while a new item may enter.
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !div_busy)
      else $error("divider busy while accepting an item");

   // A new result only appears after an emit command.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("result appeared without emit");

   // The block is ready for an item right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_tready)
      else $error("not ready after reset");

endmodule

@@ bench/tb_cascaded_moving_average_pulse_height.sv @@
// Self-checking bench for the cascaded moving average pulse height block.
// An in-bench predictor tracks records and checks every energy result in order.
// Depends on cmapa_pkg and cascaded_moving_average_pulse_height.
`timescale 1ns / 1ps

module tb_cascaded_moving_average_pulse_height;
   import cmapa_pkg::*;

   localparam int REC_MAX  = 4096;
   localparam int WIN_MAX  = 512;
   localparam int PASS_MAX = 4;
   localparam int SETTLE   = 400;   // cycles for an item still in flight

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;
   logic [0:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [CNT_W-1:0] csr_data = '0;

   cascaded_moving_average_pulse_height uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: registers, per-record latches and the running cascade.
   int unsigned      reg_len, reg_pre, reg_win, reg_pass;
   int unsigned      rec_len, rec_win, rec_pass, rec_blen, wr_slot, position;
   longint           win_sum [PASS_MAX];
   logic signed [23:0] delay_line [PASS_MAX][WIN_MAX];
   longint           peak, base_sum;
   logic signed [24:0] energy_q [$];

   int  fail_count  = 0;
   bit  no_idle     = 0;
   bit  hold_rsp    = 0;
   int  items_sent  = 0;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   // Latch the register values for a new record and clear the cascade.
   function automatic void open_record();
      int unsigned n, w, p, b;
      n = reg_len;  w = reg_win;  p = reg_pass;
      if (n < 1) n = 1;
      if (n > REC_MAX) n = REC_MAX;
      if (w < 1) w = 1;
      if (w > WIN_MAX) w = WIN_MAX;
      if (w > n) w = n;
      if (p < 1) p = 1;
      if (p > PASS_MAX) p = PASS_MAX;
      b = (reg_pre * 4) / 5;
      if (b < 1) b = 1;
      if (b > n) b = n;
      rec_len = n;  rec_win = w;  rec_pass = p;  rec_blen = b;
      wr_slot = 0;  position = 0;  peak = 0;  base_sum = 0;
      for (int i = 0; i < PASS_MAX; i++) win_sum[i] = 0;
   endfunction

   // Run one accepted sample through the cascade and queue any energy.
   function automatic void predict_energy(logic signed [7:0] s, bit first);
      longint x, dv, old;
      int unsigned pos;
      if (first || position == 0) open_record();
      pos = position;
      x   = longint'(s) * 65536;
      dv  = (pos < rec_win) ? pos + 1 : rec_win;
      for (int p = 0; p < rec_pass; p++) begin
         old = (pos >= rec_win) ? longint'(delay_line[p][wr_slot]) : 0;
         win_sum[p] += x - old;
         delay_line[p][wr_slot] = x[23:0];
         x = round_div(win_sum[p], dv);
      end
      wr_slot = (wr_slot + 1 >= rec_win) ? 0 : wr_slot + 1;
      if (pos == 0 || x > peak) peak = x;
      if (pos < rec_blen) base_sum += x;
      if (pos + 1 >= rec_len) begin
         x = peak - round_div(base_sum, rec_blen);
         energy_q.push_back(x[24:0]);
         position = 0;
      end else begin
         position = pos + 1;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item and wait for its handshake.
   task automatic send_item(logic signed [7:0] s, bit first);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      req_tuser  = first;
      do @(posedge clock); while (!req_tready);
      predict_energy(s, first);
      items_sent++;
   endtask

   // Stop offering, let every expected energy arrive and the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (energy_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val[CNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RECORD_LENGTH: reg_len  = val & 13'h1FFF;
         CSR_PRETRIGGER:    reg_pre  = val & 13'h1FFF;
         CSR_WINDOW_SIZE:   reg_win  = val & 10'h3FF;
         CSR_PASS_COUNT:    reg_pass = val & 3'h7;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(int unsigned len, int unsigned pre, int unsigned win,
                            int unsigned passes);
      wait_idle();
      csr_write(CSR_RECORD_LENGTH, len);
      csr_write(CSR_PRETRIGGER, pre);
      csr_write(CSR_WINDOW_SIZE, win);
      csr_write(CSR_PASS_COUNT, passes);
   endtask

   task automatic send_record(int unsigned n);
      for (int i = 0; i < n; i++) send_item(8'($urandom), i == 0);
   endtask

   // Reset defaults give a long record; drop it after a few extreme samples.
   task automatic test_reset_defaults();
      send_item(8'sd127, 1'b1);
      send_item(-8'sd128, 1'b0);
      send_item(8'sd0, 1'b0);
   endtask

   // Short records with field extremes, clamps and a mid-record restart.
   task automatic test_directed();
      configure(5, 5, 2, 1);
      send_item(8'sd127, 1'b1);
      send_item(-8'sd128, 1'b0);
      send_item(8'sd0, 1'b0);
      send_item(8'sd1, 1'b0);
      send_item(-8'sd1, 1'b0);
      // Every sample is its own record; pretrigger zero still gives one.
      configure(1, 0, 1, 4);
      send_item(8'sd127, 1'b0);
      send_item(-8'sd128, 1'b1);
      // Restart drops the partial record.
      configure(8, 4096, 512, 4);
      send_item(-8'sd128, 1'b1);
      send_item(8'sd127, 1'b0);
      send_item(8'sd5, 1'b0);
      send_record(8);
      // Zero registers count as the minimum.
      configure(0, 1, 0, 0);
      send_item(8'sd100, 1'b0);
      send_item(-8'sd7, 1'b1);
      // Registers above their range saturate.
      configure(6, 13, 1023, 7);
      send_record(6);
      // Oversized record length: start a record, then drop it by restart.
      configure(8191, 8191, 3, 2);
      send_item(8'sd64, 1'b1);
      send_item(8'sd33, 1'b0);
   endtask

   // Full window of the largest width on a single pass.
   task automatic test_long_window();
      configure(600, 700, 512, 1);
      send_record(600);
   endtask

   // Random short records under random settings, with some noise.
   task automatic test_random(int unsigned budget);
      int unsigned len, recs;
      while (items_sent < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                           : $urandom_range(1, 40);
         configure(($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191) % 64 : len,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(0, 60),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(1, len + 4),
                   $urandom_range(0, 7));
         no_idle = ($urandom_range(0, 4) == 0);
         recs = $urandom_range(2, 4);
         for (int r = 0; r < recs; r++) begin
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 29) == 0) send_item(8'($urandom), 1'b1);
               else send_item(8'($urandom), i == 0);
            end
            // Now and then the sender waits for all energies before going on.
            if ($urandom_range(0, 7) == 0) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               while (energy_q.size() != 0) @(posedge clock);
            end
         end
         no_idle = 0;
      end
   endtask

   // Receiver holds off while one-sample records keep arriving.
   task automatic test_backpressure();
      configure(1, 0, 1, 1);
      hold_rsp = 1;
      for (int i = 0; i < 30; i++) send_item(8'($urandom), 1'b1);
   endtask

   // Result side: random ready, with a long counted hold on request.
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp   = 0;
            rsp_tready = 1'b0;
            hold = 0;
            while (hold < 3000) begin
               @(negedge clock);
               hold++;
            end
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end else begin
            rsp_tready = no_idle || ($urandom_range(0, 99) < 75);
         end
      end
   end

   // Compare each accepted energy with the oldest prediction.
   always @(posedge clock) begin
      logic signed [24:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (energy_q.size() == 0) begin
            $error("energy result with none expected: %0d", $signed(rsp_tdata[24:0]));
            fail_count++;
         end else begin
            want = energy_q.pop_front();
            if (rsp_tdata[24:0] !== want) begin
               $error("energy mismatch: expected %0d actual %0d", want,
                      $signed(rsp_tdata[24:0]));
               fail_count++;
            end
         end
      end
   end

   initial begin
      reg_len = 4096;  reg_pre = 512;  reg_win = 500;  reg_pass = 3;
      for (int p = 0; p < PASS_MAX; p++)
         for (int k = 0; k < WIN_MAX; k++) delay_line[p][k] = '0;
      open_record();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_directed();
      test_long_window();
      test_backpressure();
      test_random(1250);
      wait_idle();
      if (fail_count == 0 && energy_q.size() == 0)
         $display("cascaded_moving_average_pulse_height verification clean");
      else
         $display("cascaded_moving_average_pulse_height verification failed");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("cascaded_moving_average_pulse_height verification failed");
      $finish;
   end

endmodule
